// ===== rtl/core/owtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_pkg: shared definitions for the 1-Wire temperature reader
// Widths, timing constants, sequencer phases, register indexes, the
// configuration and result records, and the command byte table.
// ----------------------------------------------------------------------------
package owtr_pkg;

  // Default width of the microsecond timer.
  localparam int TIMER_WIDTH_DEF = 20;

  // Widest duration that any timing register or derived slot length can ask for.
  localparam int LIMIT_W = 20;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW_TIME      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONVERSION_WAIT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_SLOT_TIME      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE_DELAY   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_RECOVERY_TIME  = 3'd6;

  // Register reset values.
  localparam logic [11:0] RESET_LOW_TIME_RST      = 12'd750;
  localparam logic [19:0] CONVERSION_WAIT_RST     = 20'd800000;
  localparam logic [9:0]  PRESENCE_WAIT_LIMIT_RST = 10'd200;
  localparam logic [9:0]  PRESENCE_LOW_LIMIT_RST  = 10'd240;
  localparam logic [7:0]  LONG_SLOT_TIME_RST      = 8'd60;
  localparam logic [7:0]  READ_SAMPLE_DELAY_RST   = 8'd12;
  localparam logic [7:0]  READ_RECOVERY_TIME_RST  = 8'd50;

  // Fixed bus timing, in ticks.
  localparam int SHORT_TIME   = 2;
  localparam int RELEASE_TIME = 15;

  // Cached temperature after reset: 26.0 degrees in 1/16 degree units.
  localparam logic [15:0] CACHE_RST = 16'd416;

  // Bus commands.
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WRITE     = 4'd5,
    PH_CONV_WAIT = 4'd6,
    PH_READ      = 4'd7
  } phase_e;

  typedef struct packed {
    logic [11:0] reset_low_time;
    logic [19:0] conversion_wait;
    logic [9:0]  presence_wait_limit;
    logic [9:0]  presence_low_limit;
    logic [7:0]  long_slot_time;
    logic [7:0]  read_sample_delay;
    logic [7:0]  read_recovery_time;
  } cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic signed [15:0] temperature;
    logic               presence_fail;
  } result_t;

  // Command sent in each byte step of the write phases.
  function automatic logic [7:0] command_byte(input logic [2:0] byte_step);
    logic [7:0] cmd;
    case (byte_step)
      3'd0:    cmd = CMD_SKIP_ROM;
      3'd1:    cmd = CMD_CONVERT;
      3'd2:    cmd = CMD_SKIP_ROM;
      3'd3:    cmd = CMD_READ_PAD;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

// ===== rtl/core/one_wire_temperature_reader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_temperature_reader: 1-Wire master that reads a bus thermometer
//
// The input channel carries one transaction per microsecond tick (action 0,
// with the sampled bus level) or a start request (action 1, ignored while a
// sequence runs). Each accepted transaction yields exactly one result
// transaction on the output channel: the open-drain drive for that tick,
// busy, done, the signed temperature in 1/16 degree and the presence fail
// flag. The configuration channel writes the seven timing registers by index
// and is always ready; indexes beyond the last register are dropped.
// When the output is not stalled, the result is in the output register on the
// cycle after acceptance. One transaction is taken per cycle while in_stall_o
// is low, and the sequencer state registers take one tick of work per clock.
// When the receiver stalls, one further result lands in a skid register and
// in_stall_o then rises until the output drains.
// Reset loads the register defaults, puts the sequencer in idle with a
// cached temperature of 26.0 degrees, and empties the output buffer.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader #(
  parameter int TIMER_WIDTH = owtr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input transactions.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic                             line_level_i,
  // Result transactions.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             drive_low_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic signed [15:0]               temperature_o,
  output logic                             presence_fail_o,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  owtr_pkg::cfg_t    cfg;
  owtr_pkg::result_t seq_res;
  owtr_pkg::result_t out_res;
  logic              buf_full;
  logic              step;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;

  // The input side stalls only when both buffer entries are occupied, so a
  // single waiting result never holds up the next tick.
  assign in_stall_o = buf_full;
  assign step       = in_valid_i & ~buf_full;

  owtr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The sequencer advances by one tick on each accepted bus tick transaction.
  owtr_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .action_i     (action_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg),
    .res_o        (seq_res)
  );

  owtr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (seq_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign drive_low_o     = out_res.drive_low;
  assign busy_res_o      = out_res.busy_res;
  assign done_res_o      = out_res.done_res;
  assign temperature_o   = out_res.temperature;
  assign presence_fail_o = out_res.presence_fail;

endmodule

// ===== rtl/core/owtr_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_cfg: timing register file
// Holds the seven bus timing registers, written one transaction at a time.
// ----------------------------------------------------------------------------
module owtr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0]   wr_index_i,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output owtr_pkg::cfg_t                     cfg_o
);

  owtr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        owtr_pkg::REG_RESET_LOW_TIME:      cfg_d.reset_low_time      = wr_data_i[11:0];
        owtr_pkg::REG_CONVERSION_WAIT:     cfg_d.conversion_wait     = wr_data_i[19:0];
        owtr_pkg::REG_PRESENCE_WAIT_LIMIT: cfg_d.presence_wait_limit = wr_data_i[9:0];
        owtr_pkg::REG_PRESENCE_LOW_LIMIT:  cfg_d.presence_low_limit  = wr_data_i[9:0];
        owtr_pkg::REG_LONG_SLOT_TIME:      cfg_d.long_slot_time      = wr_data_i[7:0];
        owtr_pkg::REG_READ_SAMPLE_DELAY:   cfg_d.read_sample_delay   = wr_data_i[7:0];
        owtr_pkg::REG_READ_RECOVERY_TIME:  cfg_d.read_recovery_time  = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time      <= owtr_pkg::RESET_LOW_TIME_RST;
      cfg_q.conversion_wait     <= owtr_pkg::CONVERSION_WAIT_RST;
      cfg_q.presence_wait_limit <= owtr_pkg::PRESENCE_WAIT_LIMIT_RST;
      cfg_q.presence_low_limit  <= owtr_pkg::PRESENCE_LOW_LIMIT_RST;
      cfg_q.long_slot_time      <= owtr_pkg::LONG_SLOT_TIME_RST;
      cfg_q.read_sample_delay   <= owtr_pkg::READ_SAMPLE_DELAY_RST;
      cfg_q.read_recovery_time  <= owtr_pkg::READ_RECOVERY_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/owtr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_seq: bus sequencer
// Advances the reset, presence, write, wait and read phases by one tick per
// accepted bus tick and forms the result record for every accepted transaction.
// ----------------------------------------------------------------------------
module owtr_seq #(
  parameter int TIMER_WIDTH = owtr_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              action_i,
  input  logic              line_level_i,
  input  owtr_pkg::cfg_t    cfg_i,
  output owtr_pkg::result_t res_o
);

  localparam int CW = (TIMER_WIDTH > owtr_pkg::LIMIT_W) ? TIMER_WIDTH : owtr_pkg::LIMIT_W;
  localparam logic [CW-1:0] TMASK = CW'((64'd1 << TIMER_WIDTH) - 64'd1);

  owtr_pkg::phase_e          phase_q, phase_d;
  logic [TIMER_WIDTH-1:0]    tick_q, tick_d;
  logic [2:0]                bit_q, bit_d;
  logic [2:0]                byte_q, byte_d;
  logic [15:0]               shift_q, shift_d;
  logic [15:0]               cache_q, cache_d;
  logic                      done_d, fail_d;

  logic [owtr_pkg::LIMIT_W-1:0] limit;
  logic [CW-1:0]                limit_ext, limit_clamp, tick_inc_ext, tick_ext;
  logic [TIMER_WIDTH-1:0]       tick_inc, tick_adv;
  logic                         hit;
  logic [8:0]                   sample_at;
  logic                         sample_hit;
  logic [7:0]                   cmd;
  logic [7:0]                   slot_low;
  logic [2:0]                   bit_inc, byte_inc;
  logic                         pres_ev, pres_ok;
  logic                         drive;

  // Shared tick timer: one increment and one compare against the phase's limit.
  always_comb begin
    case (phase_q)
      owtr_pkg::PH_RST_LOW:
        limit = owtr_pkg::LIMIT_W'(cfg_i.reset_low_time);
      owtr_pkg::PH_RST_REL:
        limit = owtr_pkg::LIMIT_W'(owtr_pkg::RELEASE_TIME);
      owtr_pkg::PH_PRES_WAIT:
        limit = owtr_pkg::LIMIT_W'(cfg_i.presence_wait_limit);
      owtr_pkg::PH_PRES_LOW:
        limit = owtr_pkg::LIMIT_W'(cfg_i.presence_low_limit);
      owtr_pkg::PH_WRITE:
        limit = owtr_pkg::LIMIT_W'(cfg_i.long_slot_time)
              + owtr_pkg::LIMIT_W'(owtr_pkg::SHORT_TIME);
      owtr_pkg::PH_CONV_WAIT:
        limit = cfg_i.conversion_wait;
      owtr_pkg::PH_READ:
        limit = owtr_pkg::LIMIT_W'(cfg_i.read_sample_delay)
              + owtr_pkg::LIMIT_W'(cfg_i.read_recovery_time)
              + owtr_pkg::LIMIT_W'(owtr_pkg::SHORT_TIME + 1);
      default:
        limit = '0;
    endcase
  end

  assign tick_inc     = tick_q + TIMER_WIDTH'(1);
  assign tick_inc_ext = CW'(tick_inc);
  assign tick_ext     = CW'(tick_q);
  assign limit_ext    = CW'(limit);
  assign limit_clamp  = (limit_ext > TMASK) ? TMASK : limit_ext;
  assign hit          = (tick_inc_ext >= limit_clamp);
  assign tick_adv     = hit ? '0 : tick_inc;

  assign sample_at  = 9'(cfg_i.read_sample_delay) + 9'(owtr_pkg::SHORT_TIME);
  assign sample_hit = (tick_ext == CW'(sample_at));

  assign cmd      = owtr_pkg::command_byte(byte_q);
  assign slot_low = cmd[bit_q] ? 8'(owtr_pkg::SHORT_TIME) : cfg_i.long_slot_time;
  assign bit_inc  = bit_q + 3'd1;
  assign byte_inc = byte_q + 3'd1;

  // Next state.
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    cache_d = cache_q;
    done_d  = 1'b0;
    fail_d  = 1'b0;
    pres_ev = 1'b0;
    pres_ok = 1'b0;
    if (action_i) begin
      if (phase_q == owtr_pkg::PH_IDLE) begin
        phase_d = owtr_pkg::PH_RST_LOW;
        tick_d  = '0;
        bit_d   = '0;
        byte_d  = '0;
        shift_d = '0;
      end
    end else begin
      case (phase_q)
        owtr_pkg::PH_RST_LOW: begin
          tick_d = tick_adv;
          if (hit) phase_d = owtr_pkg::PH_RST_REL;
        end
        owtr_pkg::PH_RST_REL: begin
          tick_d = tick_adv;
          if (hit) phase_d = owtr_pkg::PH_PRES_WAIT;
        end
        owtr_pkg::PH_PRES_WAIT: begin
          if (!line_level_i) begin
            phase_d = owtr_pkg::PH_PRES_LOW;
            tick_d  = '0;
          end else begin
            tick_d  = tick_adv;
            pres_ev = hit;
          end
        end
        owtr_pkg::PH_PRES_LOW: begin
          if (line_level_i) begin
            pres_ev = 1'b1;
            pres_ok = 1'b1;
          end else begin
            tick_d  = tick_adv;
            pres_ev = hit;
          end
        end
        owtr_pkg::PH_WRITE: begin
          tick_d = tick_adv;
          if (hit) begin
            bit_d = bit_inc;
            if (bit_inc == 3'd0) begin
              byte_d = byte_inc;
              if (byte_inc == 3'd2) begin
                phase_d = (cfg_i.conversion_wait == '0) ? owtr_pkg::PH_RST_LOW
                                                        : owtr_pkg::PH_CONV_WAIT;
              end else if (byte_inc >= 3'd4) begin
                phase_d = owtr_pkg::PH_READ;
              end
            end
          end
        end
        owtr_pkg::PH_CONV_WAIT: begin
          tick_d = tick_adv;
          if (hit) phase_d = owtr_pkg::PH_RST_LOW;
        end
        owtr_pkg::PH_READ: begin
          if (sample_hit) shift_d = {line_level_i, shift_q[15:1]};
          tick_d = tick_adv;
          if (hit) begin
            bit_d = bit_inc;
            if (bit_inc == 3'd0) begin
              byte_d = byte_inc;
              if (byte_inc >= 3'd6) begin
                cache_d = shift_d;
                phase_d = owtr_pkg::PH_IDLE;
                done_d  = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      // A presence check has come to an end, either way.
      if (pres_ev) begin
        tick_d = '0;
        bit_d  = '0;
        if (!pres_ok && byte_q >= 3'd2) begin
          phase_d = owtr_pkg::PH_IDLE;
          done_d  = 1'b1;
          fail_d  = 1'b1;
        end else begin
          phase_d = owtr_pkg::PH_WRITE;
        end
      end
    end
  end

  // Outputs. A start transaction taken in idle reports the level of the
  // coming reset pulse; the released phases drive nothing.
  always_comb begin
    case (phase_q)
      owtr_pkg::PH_RST_LOW: drive = 1'b1;
      owtr_pkg::PH_WRITE:   drive = (tick_ext < CW'(slot_low));
      owtr_pkg::PH_READ:    drive = (tick_ext < CW'(owtr_pkg::SHORT_TIME));
      default:              drive = action_i & (phase_q == owtr_pkg::PH_IDLE);
    endcase
    res_o.drive_low     = drive;
    res_o.busy_res      = (phase_d != owtr_pkg::PH_IDLE);
    res_o.done_res      = done_d;
    res_o.temperature   = $signed(cache_d);
    res_o.presence_fail = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owtr_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      cache_q <= owtr_pkg::CACHE_RST;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      cache_q <= cache_d;
    end
  end

endmodule

// ===== rtl/core/owtr_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_out_buf: two-entry result buffer
// An output register backed by a skid register, so that a result can be
// taken in while the one before it is still stalled.
// ----------------------------------------------------------------------------
module owtr_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  owtr_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output owtr_pkg::result_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  owtr_pkg::result_t out_data_q, out_data_d;
  owtr_pkg::result_t skid_data_q, skid_data_d;
  logic              pop;

  assign pop = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 1-Wire temperature reader
// A bus-slave emulation builds tick streams that walk the reader through
// whole measurements, including silent and stuck presence pulses and
// extreme temperature words. A cycle-level predictor follows every accepted
// transaction, and each result transaction is compared with its prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          TW             = owtr_pkg::TIMER_WIDTH_DEF;
  localparam int unsigned TIMER_MAX      = (32'd1 << TW) - 1;
  localparam int          TIMEOUT_CYCLES = 1500000;
  localparam int          DRAIN_CYCLES   = 4;

  // One bus tick or start request as it goes into the reader.
  typedef struct packed {
    logic action;
    logic line;
  } bus_item_t;

  // Everything the predictor needs to follow the sequencer tick by tick.
  typedef struct packed {
    owtr_pkg::cfg_t   cfg;
    owtr_pkg::phase_e ph;
    logic [TW-1:0]    ticks;
    logic [2:0]       bits;
    logic [2:0]       step;
    logic [15:0]      shreg;
    logic [15:0]      cache;
  } reader_t;

  // How the emulated thermometer answers one presence check.
  typedef enum int {
    ANSWER,
    SILENT,
    STUCK_LOW
  } slave_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic                             action_i = 1'b0;
  logic                             line_level_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic                             drive_low_o;
  logic                             busy_res_o;
  logic                             done_res_o;
  logic signed [15:0]               temperature_o;
  logic                             presence_fail_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Ticks waiting to be driven, and bus status owed by the reader.
  bus_item_t         bus_ticks_q[$];
  owtr_pkg::result_t pending_status_q[$];

  // The stimulus side keeps its own view of the reader so that the emulated
  // slave can answer at the right moment; the checking side follows only
  // what was actually accepted.
  reader_t   stim_view;
  reader_t   check_view;

  bus_item_t         next_item;
  owtr_pkg::result_t predicted;
  owtr_pkg::result_t seen;
  owtr_pkg::result_t owed;
  int                mismatch_cnt = 0;
  logic [31:0]       cyc = '0;
  logic              calm;

  // One quarter of the cycle counter's period (bits 13:12 at 01) runs with no idling on either side.
  assign calm = (cyc[13:12] == 2'b01);

  one_wire_temperature_reader dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .line_level_i    (line_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_low_o     (drive_low_o),
    .busy_res_o      (busy_res_o),
    .done_res_o      (done_res_o),
    .temperature_o   (temperature_o),
    .presence_fail_o (presence_fail_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic reader_t reader_after_reset();
    reader_t s;
    s.cfg.reset_low_time      = owtr_pkg::RESET_LOW_TIME_RST;
    s.cfg.conversion_wait     = owtr_pkg::CONVERSION_WAIT_RST;
    s.cfg.presence_wait_limit = owtr_pkg::PRESENCE_WAIT_LIMIT_RST;
    s.cfg.presence_low_limit  = owtr_pkg::PRESENCE_LOW_LIMIT_RST;
    s.cfg.long_slot_time      = owtr_pkg::LONG_SLOT_TIME_RST;
    s.cfg.read_sample_delay   = owtr_pkg::READ_SAMPLE_DELAY_RST;
    s.cfg.read_recovery_time  = owtr_pkg::READ_RECOVERY_TIME_RST;
    s.ph    = owtr_pkg::PH_IDLE;
    s.ticks = '0;
    s.bits  = '0;
    s.step  = '0;
    s.shreg = '0;
    s.cache = owtr_pkg::CACHE_RST;
    return s;
  endfunction

  // Counts one tick against a duration. A duration of zero still costs one
  // tick, and durations wider than the timer saturate at its largest count.
  function automatic bit timer_expired(inout logic [TW-1:0] ticks,
                                       input int unsigned limit);
    int unsigned lim;
    lim = (limit > TIMER_MAX) ? TIMER_MAX : limit;
    ticks = ticks + 1'b1;
    if (ticks >= lim) begin
      ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Moves to the next bit of a byte; true when the byte just finished.
  function automatic bit byte_finished(inout logic [2:0] bits, inout logic [2:0] step);
    bits = bits + 3'd1;
    if (bits == 3'd0) begin
      step = step + 3'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One transaction through the reader: a start request or a bus tick.
  // The drive level is the one for this tick, taken before the tick's work;
  // on a start it is the level the next tick will drive.
  function automatic void advance_reader(inout reader_t s, input logic act,
                                         input logic line,
                                         output owtr_pkg::result_t r);
    logic [7:0]  cmd;
    int unsigned slot_low;
    logic        drv;
    logic        done;
    logic        fail;
    int          pres;
    drv  = 1'b0;
    done = 1'b0;
    fail = 1'b0;
    pres = -1;
    if (act && s.ph == owtr_pkg::PH_IDLE) begin
      s.ph    = owtr_pkg::PH_RST_LOW;
      s.ticks = '0;
      s.bits  = '0;
      s.step  = '0;
      s.shreg = '0;
    end
    case (s.step)
      3'd0, 3'd2: cmd = owtr_pkg::CMD_SKIP_ROM;
      3'd1:       cmd = owtr_pkg::CMD_CONVERT;
      3'd3:       cmd = owtr_pkg::CMD_READ_PAD;
      default:    cmd = 8'h00;
    endcase
    case (s.ph)
      owtr_pkg::PH_RST_LOW: drv = 1'b1;
      owtr_pkg::PH_WRITE: begin
        slot_low = cmd[s.bits] ? owtr_pkg::SHORT_TIME : s.cfg.long_slot_time;
        drv = (s.ticks < slot_low);
      end
      owtr_pkg::PH_READ:  drv = (s.ticks < owtr_pkg::SHORT_TIME);
      default:            drv = 1'b0;
    endcase
    if (!act) begin
      case (s.ph)
        owtr_pkg::PH_RST_LOW: begin
          if (timer_expired(s.ticks, s.cfg.reset_low_time)) s.ph = owtr_pkg::PH_RST_REL;
        end
        owtr_pkg::PH_RST_REL: begin
          if (timer_expired(s.ticks, owtr_pkg::RELEASE_TIME)) s.ph = owtr_pkg::PH_PRES_WAIT;
        end
        owtr_pkg::PH_PRES_WAIT: begin
          if (!line) begin
            s.ph    = owtr_pkg::PH_PRES_LOW;
            s.ticks = '0;
          end else if (timer_expired(s.ticks, s.cfg.presence_wait_limit)) begin
            pres = 0;
          end
        end
        owtr_pkg::PH_PRES_LOW: begin
          if (line) pres = 1;
          else if (timer_expired(s.ticks, s.cfg.presence_low_limit)) pres = 0;
        end
        owtr_pkg::PH_WRITE: begin
          if (timer_expired(s.ticks, s.cfg.long_slot_time + owtr_pkg::SHORT_TIME)) begin
            if (byte_finished(s.bits, s.step)) begin
              // A conversion wait of zero goes straight to the second reset.
              if (s.step == 3'd2) begin
                s.ph = (s.cfg.conversion_wait == '0) ? owtr_pkg::PH_RST_LOW
                                                     : owtr_pkg::PH_CONV_WAIT;
              end else if (s.step >= 3'd4) begin
                s.ph = owtr_pkg::PH_READ;
              end
            end
          end
        end
        owtr_pkg::PH_CONV_WAIT: begin
          if (timer_expired(s.ticks, s.cfg.conversion_wait)) s.ph = owtr_pkg::PH_RST_LOW;
        end
        owtr_pkg::PH_READ: begin
          if (s.ticks == owtr_pkg::SHORT_TIME + s.cfg.read_sample_delay) begin
            s.shreg = {line, s.shreg[15:1]};
          end
          if (timer_expired(s.ticks, owtr_pkg::SHORT_TIME + s.cfg.read_sample_delay + 1
                                     + s.cfg.read_recovery_time)) begin
            if (byte_finished(s.bits, s.step)) begin
              if (s.step >= 3'd6) begin
                s.cache = s.shreg;
                s.ph    = owtr_pkg::PH_IDLE;
                done    = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      // Of the two presence checks, only the one before the read commands can end the run.
      if (pres >= 0) begin
        s.ticks = '0;
        s.bits  = '0;
        if (pres == 0 && s.step >= 3'd2) begin
          s.ph = owtr_pkg::PH_IDLE;
          done = 1'b1;
          fail = 1'b1;
        end else begin
          s.ph = owtr_pkg::PH_WRITE;
        end
      end
    end
    r.drive_low     = drv;
    r.busy_res      = (s.ph != owtr_pkg::PH_IDLE);
    r.done_res      = done;
    r.temperature   = s.cache;
    r.presence_fail = fail;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_item(input logic act, input logic line);
    bus_item_t         it;
    owtr_pkg::result_t ignored;
    it.action = act;
    it.line   = line;
    bus_ticks_q.push_back(it);
    advance_reader(stim_view, act, line, ignored);
  endfunction

  function automatic slave_mode_e pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return ANSWER;
    if (roll < 88) return SILENT;
    return STUCK_LOW;
  endfunction

  // Queues one measurement: a few idle ticks, a start, then ticks until the
  // reader is idle again (or until max_busy ticks, when that is nonzero).
  // The emulated slave pulls the line for presence and serves the data word
  // at each read sample; all other line levels are noise.
  task automatic queue_measurement(input int max_busy);
    logic [15:0] word;
    slave_mode_e mode_first;
    slave_mode_e mode_second;
    slave_mode_e mode;
    int          busy_ticks;
    logic        line;
    case ($urandom_range(0, 7))
      0:       word = 16'h8000;
      1:       word = 16'h7FFF;
      2:       word = 16'hFFFF;
      3:       word = 16'h0000;
      default: word = 16'($urandom);
    endcase
    mode_first  = pick_mode();
    mode_second = pick_mode();
    busy_ticks  = 0;
    repeat ($urandom_range(0, 3)) push_item(1'b0, 1'($urandom));
    push_item(1'b1, 1'($urandom));
    while (stim_view.ph != owtr_pkg::PH_IDLE
           && (max_busy == 0 || busy_ticks < max_busy)) begin
      if ($urandom_range(0, 63) == 0) begin
        // A start request in the middle of a run must be ignored.
        push_item(1'b1, 1'($urandom));
      end else begin
        mode = (stim_view.step < 3'd2) ? mode_first : mode_second;
        line = 1'($urandom);
        case (stim_view.ph)
          owtr_pkg::PH_PRES_WAIT: begin
            if (mode == SILENT) line = 1'b1;
            else if (mode == STUCK_LOW) line = 1'b0;
            else line = ($urandom_range(0, 2) != 0);
          end
          owtr_pkg::PH_PRES_LOW: line = (mode == ANSWER) && ($urandom_range(0, 2) == 0);
          owtr_pkg::PH_READ: begin
            if (stim_view.ticks == owtr_pkg::SHORT_TIME + stim_view.cfg.read_sample_delay)
            begin
              line = word[{stim_view.step[0], stim_view.bits}];
            end
          end
          default: ;
        endcase
        push_item(1'b0, line);
        busy_ticks++;
      end
    end
  endtask

  // Writes all seven timing registers back to back, then lowers valid once.
  task automatic apply_config(input owtr_pkg::cfg_t c);
    logic [owtr_pkg::CFG_INDEX_W-1:0] idx [7];
    logic [owtr_pkg::CFG_DATA_W-1:0]  val [7];
    idx = '{owtr_pkg::REG_RESET_LOW_TIME, owtr_pkg::REG_CONVERSION_WAIT,
            owtr_pkg::REG_PRESENCE_WAIT_LIMIT, owtr_pkg::REG_PRESENCE_LOW_LIMIT,
            owtr_pkg::REG_LONG_SLOT_TIME, owtr_pkg::REG_READ_SAMPLE_DELAY,
            owtr_pkg::REG_READ_RECOVERY_TIME};
    val = '{owtr_pkg::CFG_DATA_W'(c.reset_low_time),
            owtr_pkg::CFG_DATA_W'(c.conversion_wait),
            owtr_pkg::CFG_DATA_W'(c.presence_wait_limit),
            owtr_pkg::CFG_DATA_W'(c.presence_low_limit),
            owtr_pkg::CFG_DATA_W'(c.long_slot_time),
            owtr_pkg::CFG_DATA_W'(c.read_sample_delay),
            owtr_pkg::CFG_DATA_W'(c.read_recovery_time)};
    for (int i = 0; i < 7; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    stim_view.cfg  = c;
    check_view.cfg = c;
  endtask

  // Waits until every queued tick is accepted and every owed result has
  // arrived, then lets the output register settle.
  task automatic wait_drained();
    while (bus_ticks_q.size() != 0 || in_valid_i || pending_status_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued ticks, predicts each accepted transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      action_i     <= 1'b0;
      line_level_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_reader(check_view, action_i, line_level_i, predicted);
        pending_status_q.push_back(predicted);
      end
      // A stalled transaction holds its payload; otherwise the slot is free.
      if (!in_valid_i || !in_stall_o) begin
        if (bus_ticks_q.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
          next_item    = bus_ticks_q.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= next_item.action;
          line_level_i <= next_item.line;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the output at random and checks every result transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen.drive_low     = drive_low_o;
        seen.busy_res      = busy_res_o;
        seen.done_res      = done_res_o;
        seen.temperature   = temperature_o;
        seen.presence_fail = presence_fail_o;
        if (pending_status_q.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: result with none owed: drive=%0b busy=%0b done=%0b temp=%0d fail=%0b",
                     $realtime, seen.drive_low, seen.busy_res, seen.done_res,
                     seen.temperature, seen.presence_fail);
          end
          mismatch_cnt++;
        end else begin
          owed = pending_status_q.pop_front();
          if (seen !== owed) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: mismatch: want drive=%0b busy=%0b done=%0b temp=%0d fail=%0b",
                       $realtime, owed.drive_low, owed.busy_res, owed.done_res,
                       owed.temperature, owed.presence_fail);
              $display("%0t:             got drive=%0b busy=%0b done=%0b temp=%0d fail=%0b",
                       $realtime, seen.drive_low, seen.busy_res, seen.done_res,
                       seen.temperature, seen.presence_fail);
            end
            mismatch_cnt++;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 35);
    end
  end

  // Watchdog. A correct run ends far below this count.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == TIMEOUT_CYCLES) begin
      $display("FAIL one_wire_temperature_reader");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    owtr_pkg::cfg_t c;
    stim_view  = reader_after_reset();
    check_view = reader_after_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset timing: idle ticks at both line levels
    // report the cached 26.0 degrees, a start raises busy and announces the
    // reset pulse, a second start during the run is ignored, and the first
    // ticks of the reset pulse drive the bus low.
    push_item(1'b0, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b1);
    repeat (3) begin
      push_item(1'b0, 1'b0);
      push_item(1'b0, 1'b1);
    end
    wait_drained();

    // Shortest legal timing, conversion wait skipped. The reset pulse left
    // running above is cut short by the new, smaller duration.
    c.reset_low_time      = 12'd1;
    c.conversion_wait     = 20'd0;
    c.presence_wait_limit = 10'd1;
    c.presence_low_limit  = 10'd1;
    c.long_slot_time      = 8'd1;
    c.read_sample_delay   = 8'd1;
    c.read_recovery_time  = 8'd1;
    apply_config(c);
    repeat (2) queue_measurement(0);
    wait_drained();

    // Every duration zero: each but the skipped conversion wait acts as one
    // tick, and write slots never hold the bus low for a zero bit.
    c = '0;
    apply_config(c);
    repeat (2) queue_measurement(0);
    wait_drained();

    // Every duration at its top value except the conversion wait. Only the
    // start of the long reset pulse is run; the next setting cuts it short.
    c.reset_low_time      = 12'hFFF;
    c.conversion_wait     = 20'd0;
    c.presence_wait_limit = 10'h3FF;
    c.presence_low_limit  = 10'h3FF;
    c.long_slot_time      = 8'hFF;
    c.read_sample_delay   = 8'hFF;
    c.read_recovery_time  = 8'hFF;
    apply_config(c);
    queue_measurement(300);
    wait_drained();

    // Longest conversion wait: run into it, then leave the reader waiting.
    // The next setting shortens the wait below the count already reached.
    c.reset_low_time      = 12'd1;
    c.conversion_wait     = 20'hFFFFF;
    c.presence_wait_limit = 10'd4;
    c.presence_low_limit  = 10'd4;
    c.long_slot_time      = 8'd1;
    c.read_sample_delay   = 8'd1;
    c.read_recovery_time  = 8'd1;
    apply_config(c);
    queue_measurement(200);
    wait_drained();

    // Short random timings, one measurement per setting.
    repeat (3) begin
      c.reset_low_time      = 12'($urandom_range(0, 20));
      c.conversion_wait     = 20'($urandom_range(0, 40));
      c.presence_wait_limit = 10'($urandom_range(0, 10));
      c.presence_low_limit  = 10'($urandom_range(0, 10));
      c.long_slot_time      = 8'($urandom_range(0, 8));
      c.read_sample_delay   = 8'($urandom_range(0, 6));
      c.read_recovery_time  = 8'($urandom_range(0, 6));
      apply_config(c);
      queue_measurement(0);
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS one_wire_temperature_reader");
    end else begin
      $display("FAIL one_wire_temperature_reader");
    end
    $finish;
  end

endmodule
